// ----- hw/rtl/ftc_pkg.sv -----
// Shared types and constants for the FSM transition coverage block.
// Depends on nothing; every other file takes its names by scope.
package ftc_pkg;

  localparam int VALUE_W     = 6;
  localparam int CFG_W       = 3;
  localparam int ARC_CNT_W   = 13;
  localparam int ROW_CNT_W   = 7;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 3'd6;

  typedef struct packed {
    logic [VALUE_W-1:0] prev_value;
    logic [VALUE_W-1:0] next_value;
    logic               has_unknown;
  } in_word_t;

  typedef struct packed {
    logic                 recorded;
    logic [ARC_CNT_W-1:0] arcs_hit;
    logic [ROW_CNT_W-1:0] states_hit;
    logic [ROW_CNT_W-1:0] states_total;
    logic [ARC_CNT_W-1:0] arcs_total;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] eff_w;
    logic             clear;
  } width_ctl_t;

  function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] w,
                                                   input int max_bits);
    logic [CFG_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = CFG_W'(1);
    end else if (int'(w) > max_bits) begin
      r = CFG_W'(max_bits);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ftc_front.sv -----
// Front end: holds the width register, masks and classifies input words.
// Depends on ftc_pkg; feeds ftc_queue and the width control of ftc_back.
module ftc_front #(
  parameter int MAX_BITS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [ftc_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ftc_pkg::in_word_t        in_word,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [2*MAX_BITS:0]      q_data,
  output ftc_pkg::width_ctl_t      ctl
);

  localparam int EXT_W = (MAX_BITS > ftc_pkg::VALUE_W) ? MAX_BITS : ftc_pkg::VALUE_W;
  localparam logic [ftc_pkg::CFG_W-1:0] RST_W =
    ftc_pkg::clamp_width(ftc_pkg::WIDTH_RESET, MAX_BITS);

  logic [ftc_pkg::CFG_W-1:0] width_r;
  logic [ftc_pkg::CFG_W-1:0] width_nxt;
  logic [EXT_W-1:0]          vmask;
  logic [EXT_W-1:0]          prev_ext;
  logic [EXT_W-1:0]          next_ext;
  logic [MAX_BITS-1:0]       row;
  logic [MAX_BITS-1:0]       col;

  always_comb begin
    width_nxt = width_r;
    if (cfg_we) begin
      width_nxt = ftc_pkg::clamp_width(cfg_wdata, MAX_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= RST_W;
    end else begin
      width_r <= width_nxt;
    end
  end

  always_comb begin
    vmask    = ~({EXT_W{1'b1}} << width_r);
    prev_ext = EXT_W'(in_word.prev_value) & vmask;
    next_ext = EXT_W'(in_word.next_value) & vmask;
    row      = prev_ext[MAX_BITS-1:0];
    col      = next_ext[MAX_BITS-1:0];
  end

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign q_data    = {!in_word.has_unknown, row, col};
  assign ctl.eff_w = width_r;
  assign ctl.clear = cfg_we;

endmodule

// ----- hw/rtl/ftc_queue.sv -----
// Short word queue between the front end and the bitmap back end.
// Depends on ftc_pkg for its depth.
module ftc_queue #(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = ftc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = slot_r[rd_ptr_r];

endmodule

// ----- hw/rtl/ftc_back.sv -----
// Back end: row-organized arc bitmap memory, hit counters and result register.
// Depends on ftc_pkg; pops words from ftc_queue.
module ftc_back #(
  parameter int MAX_BITS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ftc_pkg::width_ctl_t ctl,
  input  logic                q_not_empty,
  input  logic [2*MAX_BITS:0] q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ftc_pkg::out_word_t  out_word
);

  localparam int ROWS = 1 << MAX_BITS;
  localparam int AW   = ftc_pkg::ARC_CNT_W;
  localparam int RW   = ftc_pkg::ROW_CNT_W;

  logic [ROWS-1:0] row_mem [ROWS];
  logic [ROWS-1:0] rd_data_r;
  logic [ROWS-1:0] row_vld_r, row_vld_nxt;

  logic                b_vld_r, b_vld_nxt;
  logic                b_known_r;
  logic [MAX_BITS-1:0] b_row_r;
  logic [MAX_BITS-1:0] b_col_r;

  logic                wr_vld_r, wr_vld_nxt;
  logic [MAX_BITS-1:0] wr_row_r;
  logic [ROWS-1:0]     wr_data_r;

  logic [AW-1:0] arc_cnt_r, arc_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;

  logic               out_vld_r, out_vld_nxt;
  ftc_pkg::out_word_t out_word_r;

  logic                q_known;
  logic [MAX_BITS-1:0] q_row;
  logic [MAX_BITS-1:0] q_col;
  logic                b_adv;
  logic                do_write;
  logic [ROWS-1:0]     cur_row;
  logic [ROWS-1:0]     new_row;
  logic                bit_hit;
  logic                row_new;
  ftc_pkg::out_word_t  res_word;

  assign {q_known, q_row, q_col} = q_data;

  assign b_adv    = b_vld_r && (!out_vld_r || !out_stall);
  assign q_pop    = q_not_empty && (!b_vld_r || b_adv);
  assign do_write = b_adv && b_known_r;

  always_comb begin
    if (wr_vld_r && (wr_row_r == b_row_r)) begin
      cur_row = wr_data_r;
    end else if (row_vld_r[b_row_r]) begin
      cur_row = rd_data_r;
    end else begin
      cur_row = '0;
    end
    new_row = cur_row | (ROWS'(1) << b_col_r);
    bit_hit = cur_row[b_col_r];
    row_new = !row_vld_r[b_row_r];
  end

  always_comb begin
    arc_cnt_nxt = arc_cnt_r;
    row_cnt_nxt = row_cnt_r;
    row_vld_nxt = row_vld_r;
    wr_vld_nxt  = wr_vld_r;
    if (ctl.clear) begin
      arc_cnt_nxt = '0;
      row_cnt_nxt = '0;
      row_vld_nxt = '0;
      wr_vld_nxt  = 1'b0;
    end else if (do_write) begin
      if (!bit_hit) begin
        arc_cnt_nxt = arc_cnt_r + AW'(1);
      end
      if (row_new) begin
        row_cnt_nxt = row_cnt_r + RW'(1);
      end
      row_vld_nxt[b_row_r] = 1'b1;
      wr_vld_nxt           = 1'b1;
    end
  end

  always_comb begin
    res_word.recorded     = b_known_r;
    res_word.arcs_hit     = b_known_r ? arc_cnt_nxt : arc_cnt_r;
    res_word.states_hit   = b_known_r ? row_cnt_nxt : row_cnt_r;
    res_word.states_total = RW'(1) << ctl.eff_w;
    res_word.arcs_total   = AW'(1) << {ctl.eff_w, 1'b0};
  end

  always_comb begin
    b_vld_nxt = b_vld_r;
    if (q_pop) begin
      b_vld_nxt = 1'b1;
    end else if (b_adv) begin
      b_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (b_adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      wr_vld_r  <= 1'b0;
      row_vld_r <= '0;
      arc_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= out_vld_nxt;
      wr_vld_r  <= wr_vld_nxt;
      row_vld_r <= row_vld_nxt;
      arc_cnt_r <= arc_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_known_r <= q_known;
      b_row_r   <= q_row;
      b_col_r   <= q_col;
    end
    if (do_write) begin
      wr_row_r  <= b_row_r;
      wr_data_r <= new_row;
    end
    if (b_adv) begin
      out_word_r <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data_r <= row_mem[q_row];
    end
    if (do_write) begin
      row_mem[b_row_r] <= new_row;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule

// ----- hw/rtl/fsm_transition_coverage.sv -----
// FSM transition coverage: records observed state transitions in a square
// bitmap and reports arcs hit, states hit and the totals for each word.
// Usage:
//   in_valid/in_stall/in_word carry one transition (previous value, next
//   value, unknown flag); a word is taken at an edge with in_valid high and
//   in_stall low. out_valid/out_stall/out_word return exactly one result per
//   input word, in order. cfg_we writes cfg_wdata into the state width
//   register (0 reads as 1, above MAX_STATE_BITS reads as MAX_STATE_BITS)
//   and clears the bitmap and both counts; write it only while idle.
// Throughput: one word per cycle, sustained while out_stall is low. The
//   bitmap is a memory of 2^MAX_STATE_BITS rows read at pop, ahead of its
//   read-modify-write, with the last written row forwarded so consecutive
//   hits on one row chain. Path: queue write at the accepting edge, row
//   read at pop, then update into the result register.
// Reset: rst_n low clears the queue, counts and per-row valid bits at once
//   and sets the width to 6; the bitmap needs no clearing pass.
// Stall: out_stall holds the result; the back end then stops popping and the
//   queue (4 words) fills before in_stall rises.
module fsm_transition_coverage #(
  parameter int MAX_STATE_BITS = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ftc_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ftc_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ftc_pkg::out_word_t        out_word
);

  localparam int QW = 2 * MAX_STATE_BITS + 1;

  ftc_pkg::width_ctl_t ctl;
  logic                q_push;
  logic [QW-1:0]       q_wdata;
  logic                q_full;
  logic                q_pop;
  logic                q_not_empty;
  logic [QW-1:0]       q_head;

  ftc_front #(.MAX_BITS(MAX_STATE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .ctl      (ctl)
  );

  ftc_queue #(.WIDTH(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_data(q_head)
  );

  ftc_back #(.MAX_BITS(MAX_STATE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .q_not_empty(q_not_empty),
    .q_data     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

// ----- hw/rtl/ftc_checker.sv -----
// Port-level checks on the transition coverage block's result channel.
// Depends on ftc_pkg; bound to fsm_transition_coverage below.
module ftc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_we,
  input logic               out_valid,
  input logic               out_stall,
  input ftc_pkg::out_word_t out_word
);

  logic                         out_acc;
  logic [ftc_pkg::ARC_CNT_W-1:0] st_sq;

  assign out_acc = out_valid && !out_stall;
  assign st_sq   = ftc_pkg::ARC_CNT_W'(out_word.states_total) *
                   ftc_pkg::ARC_CNT_W'(out_word.states_total);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.arcs_total == st_sq)
    else $error("arc total is not the square of the state total");

  a_rows_le_arcs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.states_total != '0 |->
      out_word.arcs_hit >= ftc_pkg::ARC_CNT_W'(out_word.states_hit) &&
      out_word.states_hit <= out_word.states_total)
    else $error("hit counts out of range");

  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc ##1 out_acc |->
      $past(cfg_we) || out_word.states_total == '0 ||
      (out_word.arcs_hit >= $past(out_word.arcs_hit) &&
       out_word.states_hit >= $past(out_word.states_hit)))
    else $error("hit counts decreased without a width write");

endmodule

bind fsm_transition_coverage ftc_checker u_ftc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .cfg_we   (cfg_we),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);

// ----- verif/fsm_transition_coverage_tb.sv -----
// Testbench for fsm_transition_coverage: drives transition words and checks every result
// against an in-bench bitmap model, across widths, idle gaps and output stalls.
// Depends on ftc_pkg and the fsm_transition_coverage RTL.
`timescale 1ns / 100ps

module fsm_transition_coverage_tb;

  localparam int MAX_BITS     = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [ftc_pkg::CFG_W-1:0] cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  ftc_pkg::in_word_t         in_word;
  logic                      out_valid;
  logic                      out_stall;
  ftc_pkg::out_word_t        out_word;

  bit                        arc_seen [0:(1 << (2 * MAX_BITS)) - 1];
  bit                        row_seen [0:(1 << MAX_BITS) - 1];
  int unsigned               arc_hits;
  int unsigned               row_hits;
  logic [ftc_pkg::CFG_W-1:0] width_reg;

  ftc_pkg::out_word_t          pending_results[$];
  ftc_pkg::out_word_t          want;
  int unsigned                 mismatch_cnt;
  int unsigned                 cycle_cnt;
  bit                          drv_valid;
  bit                          gaps_on;
  bit                          stalls_on;
  int unsigned                 hold_len;
  logic [ftc_pkg::VALUE_W-1:0] last_next;

  fsm_transition_coverage #(
    .MAX_STATE_BITS(MAX_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** fsm_transition_coverage: FAILED **");
      $finish;
    end
  end

  function automatic void clear_coverage();
    foreach (arc_seen[i]) arc_seen[i] = 1'b0;
    foreach (row_seen[i]) row_seen[i] = 1'b0;
    arc_hits = 0;
    row_hits = 0;
  endfunction

  function automatic ftc_pkg::out_word_t predict_coverage(ftc_pkg::in_word_t w);
    int unsigned        eff;
    int unsigned        states;
    int unsigned        from;
    int unsigned        to;
    ftc_pkg::out_word_t r;
    eff = int'(width_reg);
    if (eff == 0) eff = 1;
    if (eff > MAX_BITS) eff = MAX_BITS;
    states = 1 << eff;
    from = int'(w.prev_value) & (states - 1);
    to = int'(w.next_value) & (states - 1);
    r.recorded = !w.has_unknown;
    if (!w.has_unknown) begin
      if (!arc_seen[(from << eff) | to]) begin
        arc_seen[(from << eff) | to] = 1'b1;
        arc_hits++;
      end
      if (!row_seen[from]) begin
        row_seen[from] = 1'b1;
        row_hits++;
      end
    end
    r.arcs_hit = ftc_pkg::ARC_CNT_W'(arc_hits);
    r.states_hit = ftc_pkg::ROW_CNT_W'(row_hits);
    r.states_total = ftc_pkg::ROW_CNT_W'(states);
    r.arcs_total = ftc_pkg::ARC_CNT_W'(states * states);
    return r;
  endfunction

  task automatic idle_input();
    if (drv_valid) begin
      in_valid <= 1'b0;
      drv_valid = 1'b0;
    end
  endtask

  task automatic send_transition(input logic [ftc_pkg::VALUE_W-1:0] prev,
                                 input logic [ftc_pkg::VALUE_W-1:0] next,
                                 input logic unknown);
    ftc_pkg::in_word_t w;
    int unsigned       gap;
    int unsigned       pick;
    w.prev_value = prev;
    w.next_value = next;
    w.has_unknown = unknown;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) begin
        gap = $urandom_range(10, 30);
      end else if (pick >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      idle_input();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv_valid = 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_coverage(w));
    last_next = next;
  endtask

  task automatic wait_results_drained();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_state_width(input logic [ftc_pkg::CFG_W-1:0] value);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = value;
    clear_coverage();
  endtask

  // receiver: long hold on request, else random stall bursts
  initial begin
    int unsigned burst;
    int unsigned pick;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        hold_len--;
      end else if (!stalls_on) begin
        out_stall <= 1'b0;
        burst = 0;
      end else if (burst != 0) begin
        burst--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_stall <= 1'b0;
          burst = $urandom_range(0, 7);
        end else if (pick < 95) begin
          out_stall <= 1'b1;
          burst = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          burst = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
          $display("%0t: result word with nothing expected: %p", $realtime, out_word);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_word.recorded !== want.recorded || out_word.arcs_hit !== want.arcs_hit ||
            out_word.states_hit !== want.states_hit ||
            out_word.states_total !== want.states_total ||
            out_word.arcs_total !== want.arcs_total) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("%0t: mismatch rec %b/%b arcs %0d/%0d states %0d/%0d tot %0d/%0d %0d/%0d",
                     $realtime, want.recorded, out_word.recorded, want.arcs_hit,
                     out_word.arcs_hit, want.states_hit, out_word.states_hit,
                     want.states_total, out_word.states_total, want.arcs_total,
                     out_word.arcs_total);
          end
        end
      end
    end
  end

  task automatic test_reset_width();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_transition(6'd0, 6'd0, 1'b0);
    send_transition(6'd0, 6'd0, 1'b0);
    send_transition(6'd63, 6'd63, 1'b0);
    send_transition(6'd63, 6'd0, 1'b0);
    send_transition(6'd0, 6'd63, 1'b0);
    send_transition(6'd21, 6'd42, 1'b1);
    send_transition(6'd42, 6'd21, 1'b0);
    send_transition(6'd42, 6'd21, 1'b1);
    send_transition(6'd42, 6'd22, 1'b0);
  endtask

  task automatic test_width_extremes();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_state_width(3'd0);
    send_transition(6'd63, 6'd62, 1'b0);
    send_transition(6'd3, 6'd2, 1'b0);
    send_transition(6'd0, 6'd1, 1'b0);
    send_transition(6'd1, 6'd1, 1'b0);
    send_transition(6'd0, 6'd0, 1'b0);
    write_state_width(3'd7);
    send_transition(6'd63, 6'd63, 1'b0);
    send_transition(6'd1, 6'd2, 1'b1);
    write_state_width(3'd1);
    send_transition(6'd2, 6'd3, 1'b0);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_state_width(3'd3);
    hold_len = 120;
    repeat (30) send_transition(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0);
  endtask

  task automatic test_drain_pause();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (20) send_transition(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0);
    wait_results_drained();
    repeat (20) send_transition(last_next, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_walks();
    logic [ftc_pkg::CFG_W-1:0]   widths[9] = '{3'd6, 3'd2, 3'd5, 3'd1, 3'd3, 3'd7, 3'd4,
                                               3'd0, 3'd6};
    logic [ftc_pkg::VALUE_W-1:0] prev;
    logic                        unknown;
    int unsigned                 n;
    foreach (widths[p]) begin
      write_state_width(widths[p]);
      gaps_on = (p != 2);
      stalls_on = (p != 2) && (p != 6);
      n = $urandom_range(60, 90);
      repeat (n) begin
        unknown = ($urandom_range(0, 99) < 12);
        if ($urandom_range(0, 99) < 65) begin
          prev = last_next;
        end else begin
          prev = 6'($urandom_range(0, 63));
        end
        send_transition(prev, 6'($urandom_range(0, 63)), unknown);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_word = '0;
    drv_valid = 1'b0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_len = 0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    last_next = '0;
    width_reg = ftc_pkg::WIDTH_RESET;
    clear_coverage();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_width();
    test_width_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_walks();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("** fsm_transition_coverage: PASSED **");
    end else begin
      $display("** fsm_transition_coverage: FAILED **");
    end
    $finish;
  end

endmodule
